// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the auto-repeat design files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define DAR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define DAR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/dar_pkg.sv =====
// ---------------------------------------------------------------------------
// dar_pkg
// Shared types and codes for the directional auto-repeat block.
// ---------------------------------------------------------------------------
package dar_pkg;

   localparam int NUM_LANES      = 4;
   localparam int ELAPSED_BITS   = 16;
   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [1:0] {
      DIR_NONE = 2'd0,
      DIR_POS  = 2'd1,
      DIR_NEG  = 2'd2
   } dir_type;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_AXIS_THRESHOLD  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_DELAY     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REPEAT_INTERVAL = 2'd2;

   // lanes: stick x, stick y, button x, button y
   localparam int LANE_STICK_X  = 0;
   localparam int LANE_STICK_Y  = 1;
   localparam int LANE_BUTTON_X = 2;
   localparam int LANE_BUTTON_Y = 3;

   typedef struct packed {
      logic stick_right;
      logic stick_left;
      logic stick_up;
      logic stick_down;
      logic button_right;
      logic button_left;
      logic button_up;
      logic button_down;
   } pulse_type;

endpackage

// ===== design/dar_lane.sv =====
// ---------------------------------------------------------------------------
// dar_lane
// One auto-repeat channel: hold timer, last direction and pulse decision.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dar_lane #(
   parameter int TIME_BITS = 20
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step,
   input  dar_pkg::dir_type                  dir_in,
   input  logic [dar_pkg::ELAPSED_BITS-1:0]  elapsed,
   input  logic [TIME_BITS-1:0]              hold_delay,
   input  logic [TIME_BITS-1:0]              repeat_interval,
   output dar_pkg::dir_type                  fire
);

   localparam int TimerBits = TIME_BITS + 2;
   localparam int SumBits   =
      ((TimerBits > dar_pkg::ELAPSED_BITS + 1) ? TimerBits : dar_pkg::ELAPSED_BITS + 1) + 1;

   logic signed [TimerBits-1:0] timer_ff, timer_in;
   dar_pkg::dir_type            last_ff, last_in;

   logic signed [SumBits-1:0]   sum;
   logic signed [SumBits-1:0]   tmax_ext;
   logic signed [TimerBits-1:0] tmax;
   logic signed [TimerBits-1:0] sat;
   logic signed [TimerBits-1:0] delay_s;
   logic signed [TimerBits-1:0] interval_s;
   logic                        due;

   assign tmax       = {1'b0, {(TimerBits-1){1'b1}}};
   assign tmax_ext   = {{(SumBits-TimerBits){1'b0}}, tmax};
   assign sum        = {{(SumBits-TimerBits){timer_ff[TimerBits-1]}}, timer_ff}
                     + $signed({{(SumBits-dar_pkg::ELAPSED_BITS){1'b0}}, elapsed});
   assign sat        = (sum > tmax_ext) ? tmax : sum[TimerBits-1:0];
   assign delay_s    = {2'b00, hold_delay};
   assign interval_s = {2'b00, repeat_interval};
   assign due        = (sat >= delay_s);

   always_comb begin
      timer_in = timer_ff;
      last_in  = last_ff;
      fire     = dar_pkg::DIR_NONE;
      if (dir_in == dar_pkg::DIR_NONE) begin
         timer_in = '0;
         last_in  = dar_pkg::DIR_NONE;
      end else if (dir_in != last_ff) begin
         timer_in = '0;
         last_in  = dir_in;
         fire     = dir_in;
      end else if (due) begin
         timer_in = sat - interval_s;
         fire     = dir_in;
      end else begin
         timer_in = sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         last_ff  <= dar_pkg::DIR_NONE;
      end else if (step) begin
         timer_ff <= timer_in;
         last_ff  <= last_in;
      end
   end

   `DAR_ASSERT(a_release_clears, clock, reset, (step && dir_in == dar_pkg::DIR_NONE) |=> (last_ff == dar_pkg::DIR_NONE && timer_ff == '0), "released channel not cleared")
   `DAR_ASSERT(a_fire_matches_dir, clock, reset, (fire == dar_pkg::DIR_NONE) || (fire == dir_in), "pulse direction differs from input direction")

endmodule

// ===== design/dar_merge.sv =====
// ---------------------------------------------------------------------------
// dar_merge
// Gathers the lane pulses into one result beat and buffers two beats.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dar_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  dar_pkg::dir_type    fire [dar_pkg::NUM_LANES],
   output logic                can_take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output dar_pkg::pulse_type  rsp_pulses
);

   dar_pkg::pulse_type merged;
   dar_pkg::pulse_type head_ff, tail_ff;
   logic               head_valid_ff, tail_valid_ff;
   logic               pop;
   logic               head_load;

   always_comb begin
      merged.stick_right  = (fire[dar_pkg::LANE_STICK_X]  == dar_pkg::DIR_POS);
      merged.stick_left   = (fire[dar_pkg::LANE_STICK_X]  == dar_pkg::DIR_NEG);
      merged.stick_up     = (fire[dar_pkg::LANE_STICK_Y]  == dar_pkg::DIR_POS);
      merged.stick_down   = (fire[dar_pkg::LANE_STICK_Y]  == dar_pkg::DIR_NEG);
      merged.button_right = (fire[dar_pkg::LANE_BUTTON_X] == dar_pkg::DIR_POS);
      merged.button_left  = (fire[dar_pkg::LANE_BUTTON_X] == dar_pkg::DIR_NEG);
      merged.button_up    = (fire[dar_pkg::LANE_BUTTON_Y] == dar_pkg::DIR_POS);
      merged.button_down  = (fire[dar_pkg::LANE_BUTTON_Y] == dar_pkg::DIR_NEG);
   end

   assign pop        = head_valid_ff && rsp_ready;
   assign head_load  = !head_valid_ff || pop;
   assign can_take   = !tail_valid_ff;
   assign rsp_valid  = head_valid_ff;
   assign rsp_pulses = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else if (head_load) begin
         head_valid_ff <= tail_valid_ff || push;
         tail_valid_ff <= 1'b0;
      end else if (push) begin
         tail_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (head_load) begin
         head_ff <= tail_valid_ff ? tail_ff : merged;
      end else if (push) begin
         tail_ff <= merged;
      end
   end

   `DAR_ASSERT_ALWAYS(a_tail_needs_head, clock, reset || !(tail_valid_ff && !head_valid_ff), "skid beat held without output beat")
   `DAR_ASSERT(a_no_push_when_full, clock, reset, tail_valid_ff |-> !push, "beat pushed into full buffer")

endmodule

// ===== design/directional_auto_repeat_top.sv =====
// ---------------------------------------------------------------------------
// directional_auto_repeat_top
// Typematic auto-repeat for stick and direction-pad inputs of one pad.
// ---------------------------------------------------------------------------
// Takes one tick beat per clock while req_ready is high and returns one
// result beat per tick, the cycle after acceptance at the earliest. Four
// lanes (stick X, stick Y, button X, button Y) each update their hold timer
// on every accepted tick, and a two-entry result buffer lets one more tick in
// while the output stalls, so the sustained rate is one tick per cycle while
// rsp_ready is high. Registers: 0 axis threshold, 1 start delay, 2 repeat
// interval; write them only while no tick is in flight.
// ---------------------------------------------------------------------------
module directional_auto_repeat_top #(
   parameter int AXIS_BITS = 16,
   parameter int TIME_BITS = 20,
   localparam int CsrDataBits = (AXIS_BITS - 1 > TIME_BITS) ? AXIS_BITS - 1 : TIME_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [AXIS_BITS-1:0]          req_stick_x,
   input  logic signed [AXIS_BITS-1:0]          req_stick_y,
   input  logic                                 req_press_right,
   input  logic                                 req_press_left,
   input  logic                                 req_press_up,
   input  logic                                 req_press_down,
   input  logic [dar_pkg::ELAPSED_BITS-1:0]     req_elapsed,

   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_stick_right_pulse,
   output logic                                 rsp_stick_left_pulse,
   output logic                                 rsp_stick_up_pulse,
   output logic                                 rsp_stick_down_pulse,
   output logic                                 rsp_button_right_pulse,
   output logic                                 rsp_button_left_pulse,
   output logic                                 rsp_button_up_pulse,
   output logic                                 rsp_button_down_pulse,

   input  logic                                 csr_write_en,
   input  logic [dar_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CsrDataBits-1:0]               csr_wdata
);

   logic [AXIS_BITS-2:0]        threshold_ff;
   logic [TIME_BITS-1:0]        delay_ff;
   logic [TIME_BITS-1:0]        interval_ff;

   logic signed [AXIS_BITS-1:0] pos_limit;
   logic signed [AXIS_BITS-1:0] neg_limit;
   logic                        step;
   dar_pkg::dir_type            lane_dir  [dar_pkg::NUM_LANES];
   dar_pkg::dir_type            lane_fire [dar_pkg::NUM_LANES];
   dar_pkg::pulse_type          pulses;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= (AXIS_BITS-1)'(16384);
         delay_ff     <= TIME_BITS'(500);
         interval_ff  <= TIME_BITS'(100);
      end else if (csr_write_en) begin
         unique case (csr_index)
            dar_pkg::CSR_AXIS_THRESHOLD:  threshold_ff <= csr_wdata[AXIS_BITS-2:0];
            dar_pkg::CSR_START_DELAY:     delay_ff     <= csr_wdata[TIME_BITS-1:0];
            dar_pkg::CSR_REPEAT_INTERVAL: interval_ff  <= csr_wdata[TIME_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign pos_limit = $signed({1'b0, threshold_ff});
   assign neg_limit = -pos_limit;
   assign step      = req_valid && req_ready;

   always_comb begin
      priority if (req_stick_x > pos_limit) lane_dir[dar_pkg::LANE_STICK_X] = dar_pkg::DIR_POS;
      else if (req_stick_x < neg_limit)     lane_dir[dar_pkg::LANE_STICK_X] = dar_pkg::DIR_NEG;
      else                                  lane_dir[dar_pkg::LANE_STICK_X] = dar_pkg::DIR_NONE;

      priority if (req_stick_y > pos_limit) lane_dir[dar_pkg::LANE_STICK_Y] = dar_pkg::DIR_POS;
      else if (req_stick_y < neg_limit)     lane_dir[dar_pkg::LANE_STICK_Y] = dar_pkg::DIR_NEG;
      else                                  lane_dir[dar_pkg::LANE_STICK_Y] = dar_pkg::DIR_NONE;

      // right beats left, up beats down
      priority if (req_press_right) lane_dir[dar_pkg::LANE_BUTTON_X] = dar_pkg::DIR_POS;
      else if (req_press_left)      lane_dir[dar_pkg::LANE_BUTTON_X] = dar_pkg::DIR_NEG;
      else                          lane_dir[dar_pkg::LANE_BUTTON_X] = dar_pkg::DIR_NONE;

      priority if (req_press_up)    lane_dir[dar_pkg::LANE_BUTTON_Y] = dar_pkg::DIR_POS;
      else if (req_press_down)      lane_dir[dar_pkg::LANE_BUTTON_Y] = dar_pkg::DIR_NEG;
      else                          lane_dir[dar_pkg::LANE_BUTTON_Y] = dar_pkg::DIR_NONE;
   end

   for (genvar i = 0; i < dar_pkg::NUM_LANES; i++) begin : g_lane
      dar_lane #(
         .TIME_BITS (TIME_BITS)
      ) u_lane (
         .clock           (clock),
         .reset           (reset),
         .step            (step),
         .dir_in          (lane_dir[i]),
         .elapsed         (req_elapsed),
         .hold_delay      (delay_ff),
         .repeat_interval (interval_ff),
         .fire            (lane_fire[i])
      );
   end

   dar_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .push       (step),
      .fire       (lane_fire),
      .can_take   (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_pulses (pulses)
   );

   assign rsp_stick_right_pulse  = pulses.stick_right;
   assign rsp_stick_left_pulse   = pulses.stick_left;
   assign rsp_stick_up_pulse     = pulses.stick_up;
   assign rsp_stick_down_pulse   = pulses.stick_down;
   assign rsp_button_right_pulse = pulses.button_right;
   assign rsp_button_left_pulse  = pulses.button_left;
   assign rsp_button_up_pulse    = pulses.button_up;
   assign rsp_button_down_pulse  = pulses.button_down;

endmodule
